@@ rtl/frpc_pkg.sv @@
package frpc_pkg;

   localparam int ACTION_W    = 4;
   localparam int FRAME_W     = 64;
   localparam int ID_W        = 31;
   localparam int STATUS_W    = 3;
   localparam int COUNT_W     = 11;
   localparam int BELL_W      = 32;
   localparam int DEPTH_LIMIT = 16384;

   localparam logic [BELL_W-1:0] BELL_RUNG = 32'h8000_0000;
   localparam logic [BELL_W-1:0] BELL_ALL  = 32'hFFFF_FFFF;

   localparam logic REG_CAP_LOG2 = 1'b0;
   localparam logic REG_STREAM   = 1'b1;
   localparam logic [3:0] CAP_LOG2_RESET = 4'd10;

   typedef enum logic [ACTION_W-1:0] {
      ACT_PUSH       = 4'd0,
      ACT_POP        = 4'd1,
      ACT_W_ATTACH   = 4'd2,
      ACT_W_DETACH   = 4'd3,
      ACT_R_ATTACH   = 4'd4,
      ACT_R_DETACH   = 4'd5,
      ACT_HANG_WBELL = 4'd6,
      ACT_HANG_RBELL = 4'd7,
      ACT_TAKE_WBELL = 4'd8,
      ACT_TAKE_RBELL = 4'd9
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK          = 3'd0,
      ST_WOULD_BLOCK = 3'd1,
      ST_READER_TERM = 3'd2,
      ST_WRITER_CLOS = 3'd3,
      ST_INVALID_ARG = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      PRES_NONE     = 2'd0,
      PRES_ATTACHED = 2'd1,
      PRES_GONE     = 2'd2,
      PRES_FROZEN   = 2'd3
   } presence_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

endpackage

@@ rtl/frame_ring_with_peer_close_unit.sv @@
// Each result passes through the stage A register and then the stage B output register.
// Throughput: one transaction per cycle while the result side keeps up.
// Pointers and flags update in the accept cycle; the slot RAM read is registered.
// Reset (synchronous): pointers, presence and doorbells cleared, capacity_log2 = 10,
// stream_mode = 0; slot contents stay undefined until written.
module frame_ring_with_peer_close_unit import frpc_pkg::*; #(
   parameter int DEPTH      = 1024,
   parameter int FRAME_BITS = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,  // frame_in[63:0], waiter_id[94:64], pad
   input  logic [3:0]   req_tuser,  // action[3:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [119:0] rsp_tdata,  // frame_out[63:0], notify_id[94:64],
                                    // fill_count[105:95], free_count[116:106], pad
   output logic [3:0]   rsp_tuser,  // status[2:0], notify_valid[3]
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam int DCLAMP = (DEPTH > DEPTH_LIMIT) ? DEPTH_LIMIT : DEPTH;
   localparam int MAXL   = ((1 << $clog2(DCLAMP)) > DCLAMP) ? $clog2(DCLAMP) - 1
                                                             : $clog2(DCLAMP);
   localparam int AW     = MAXL;
   localparam int PW     = MAXL + 1;

   // architectural state
   logic [PW-1:0]     wp_ff, wp_in, rp_ff, rp_in;
   presence_type      wpres_ff, wpres_in, rpres_ff, rpres_in;
   logic [BELL_W-1:0] wbell_ff, wbell_in, rbell_ff, rbell_in;
   logic [3:0]        cap_log2_ff, cap_log2_in;
   logic              stream_ff, stream_in;

   // stage A: step done, RAM read in flight
   logic               a_valid_ff, a_valid_in;
   status_type         a_status_ff, a_status_in;
   logic               a_pop_ff, a_pop_in;
   logic               a_nv_ff, a_nv_in;
   logic [ID_W-1:0]    a_nid_ff, a_nid_in;
   logic [COUNT_W-1:0] a_fill_ff, a_fill_in, a_free_ff, a_free_in;

   // stage B: output register
   logic         b_valid_ff, b_valid_in;
   logic [119:0] b_data_ff, b_data_in;
   logic [3:0]   b_user_ff, b_user_in;

   logic              accept, a_move, csr_wr;
   action_type        action;
   logic [ID_W-1:0]   wid;
   logic [3:0]        k;
   logic [PW-1:0]     cap, cap_m1, fill, fill_nx, free_nx;
   mem_ctl_type       mem_ctl;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [FRAME_BITS-1:0] rd_data;
   logic [PW+COUNT_W-1:0] fill_wide, free_wide;
   logic [FRAME_W+FRAME_BITS-1:0] fout_wide;

   assign action = action_type'(req_tuser);
   assign wid    = req_tdata[FRAME_W +: ID_W];
   assign csr_wr = csr_psel & csr_penable & csr_pwrite & csr_pready;

   assign a_move     = !b_valid_ff || rsp_tready;
   assign req_tready = !a_valid_ff || a_move;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      if (cap_log2_ff < 4'd1) begin
         k = 4'd1;
      end else if (cap_log2_ff > 4'(MAXL)) begin
         k = 4'(MAXL);
      end else begin
         k = cap_log2_ff;
      end
   end

   assign cap     = PW'(1) << k;
   assign cap_m1  = cap - PW'(1);
   assign fill    = wp_ff - rp_ff;
   assign wr_addr = wp_ff[AW-1:0] & cap_m1[AW-1:0];
   assign rd_addr = rp_ff[AW-1:0] & cap_m1[AW-1:0];

   always_comb begin
      wp_in       = wp_ff;
      rp_in       = rp_ff;
      wpres_in    = wpres_ff;
      rpres_in    = rpres_ff;
      wbell_in    = wbell_ff;
      rbell_in    = rbell_ff;
      cap_log2_in = cap_log2_ff;
      stream_in   = stream_ff;
      a_status_in = ST_OK;
      a_pop_in    = 1'b0;
      a_nv_in     = 1'b0;
      a_nid_in    = '0;
      mem_ctl     = '0;
      if (accept) begin
         case (action)
            ACT_PUSH: begin
               if (fill < cap) begin
                  mem_ctl.wr_en = 1'b1;
                  wp_in = wp_ff + PW'(1);
                  if (rbell_ff != '0 && (rbell_ff & BELL_RUNG) == '0) begin
                     rbell_in = rbell_ff | BELL_RUNG;
                     a_nv_in  = 1'b1;
                     a_nid_in = rbell_ff[ID_W-1:0];
                  end
               end else if (!stream_ff && rpres_ff == PRES_GONE) begin
                  rpres_in    = PRES_FROZEN;
                  a_status_in = ST_READER_TERM;
               end else begin
                  a_status_in = ST_WOULD_BLOCK;
               end
            end
            ACT_POP: begin
               if (fill != '0) begin
                  mem_ctl.rd_en = 1'b1;
                  a_pop_in = 1'b1;
                  rp_in = rp_ff + PW'(1);
                  if (wbell_ff != '0 && (wbell_ff & BELL_RUNG) == '0) begin
                     wbell_in = wbell_ff | BELL_RUNG;
                     a_nv_in  = 1'b1;
                     a_nid_in = wbell_ff[ID_W-1:0];
                  end
               end else if (!stream_ff && wpres_ff == PRES_GONE) begin
                  wpres_in    = PRES_FROZEN;
                  a_status_in = ST_WRITER_CLOS;
               end else begin
                  a_status_in = ST_WOULD_BLOCK;
               end
            end
            ACT_W_ATTACH: wpres_in = PRES_ATTACHED;
            ACT_W_DETACH: begin
               if (wpres_ff != PRES_NONE) wpres_in = PRES_GONE;
               wbell_in = '0;
            end
            ACT_R_ATTACH: rpres_in = PRES_ATTACHED;
            ACT_R_DETACH: begin
               if (rpres_ff != PRES_NONE) rpres_in = PRES_GONE;
               rbell_in = '0;
            end
            ACT_HANG_WBELL: begin
               if (wid == '0) a_status_in = ST_INVALID_ARG;
               else wbell_in = {1'b0, wid};
            end
            ACT_HANG_RBELL: begin
               if (wid == '0) a_status_in = ST_INVALID_ARG;
               else rbell_in = {1'b0, wid};
            end
            ACT_TAKE_WBELL: wbell_in = '0;
            ACT_TAKE_RBELL: rbell_in = '0;
            default: a_status_in = ST_INVALID_ARG;
         endcase
      end
      if (csr_wr) begin
         if (csr_paddr[2] == REG_CAP_LOG2) begin
            cap_log2_in = csr_pwdata[3:0];
            wp_in = '0;
            rp_in = '0;
         end else begin
            stream_in = csr_pwdata[0];
         end
      end
   end

   assign fill_nx   = wp_in - rp_in;
   assign free_nx   = (fill_nx >= cap) ? '0 : cap - fill_nx;
   assign fill_wide = {{COUNT_W{1'b0}}, fill_nx};
   assign free_wide = {{COUNT_W{1'b0}}, free_nx};
   assign a_fill_in = fill_wide[COUNT_W-1:0];
   assign a_free_in = free_wide[COUNT_W-1:0];

   assign a_valid_in = accept ? 1'b1 : (a_move ? 1'b0 : a_valid_ff);

   assign fout_wide = {{FRAME_W{1'b0}}, (a_pop_ff ? rd_data : '0)};

   always_comb begin
      b_valid_in = b_valid_ff;
      b_data_in  = b_data_ff;
      b_user_in  = b_user_ff;
      if (a_valid_ff && a_move) begin
         b_valid_in = 1'b1;
         b_data_in  = {3'b000, a_free_ff, a_fill_ff, a_nid_ff, fout_wide[FRAME_W-1:0]};
         b_user_in  = {a_nv_ff, a_status_ff};
      end else if (rsp_tready) begin
         b_valid_in = 1'b0;
      end
   end

   frpc_ring #(
      .FRAME_BITS(FRAME_BITS),
      .AW        (AW)
   ) u_ring (
      .clock  (clock),
      .ctl    (mem_ctl),
      .wr_addr(wr_addr),
      .wr_data(req_tdata[FRAME_BITS-1:0]),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff       <= '0;
         rp_ff       <= '0;
         wpres_ff    <= PRES_NONE;
         rpres_ff    <= PRES_NONE;
         wbell_ff    <= '0;
         rbell_ff    <= '0;
         cap_log2_ff <= CAP_LOG2_RESET;
         stream_ff   <= 1'b0;
         a_valid_ff  <= 1'b0;
         b_valid_ff  <= 1'b0;
      end else begin
         wp_ff       <= wp_in;
         rp_ff       <= rp_in;
         wpres_ff    <= wpres_in;
         rpres_ff    <= rpres_in;
         wbell_ff    <= wbell_in;
         rbell_ff    <= rbell_in;
         cap_log2_ff <= cap_log2_in;
         stream_ff   <= stream_in;
         a_valid_ff  <= a_valid_in;
         b_valid_ff  <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_status_ff <= a_status_in;
         a_pop_ff    <= a_pop_in;
         a_nv_ff     <= a_nv_in;
         a_nid_ff    <= a_nid_in;
         a_fill_ff   <= a_fill_in;
         a_free_ff   <= a_free_in;
      end
      b_data_ff <= b_data_in;
      b_user_ff <= b_user_in;
   end

   assign rsp_tvalid = b_valid_ff;
   assign rsp_tdata  = b_data_ff;
   assign rsp_tuser  = b_user_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_STREAM) ? {31'd0, stream_ff}
                                                    : {28'd0, cap_log2_ff};

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill <= cap)
      else $error("fill exceeds capacity");

   a_write_room: assert property (@(posedge clock) disable iff (reset)
      mem_ctl.wr_en |-> (fill < cap && wp_in == wp_ff + PW'(1)))
      else $error("slot write without room");

   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      accept |=> a_valid_ff)
      else $error("accepted transaction lost");

   a_notify_id: assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && a_nv_ff) |-> (a_nid_ff != '0 && a_status_ff == ST_OK))
      else $error("notify without waiter");

   a_pop_ok: assert property (@(posedge clock) disable iff (reset)
      accept |=> (a_pop_ff == $past(mem_ctl.rd_en)))
      else $error("pop result without slot read");

endmodule

@@ rtl/frpc_ring.sv @@
module frpc_ring import frpc_pkg::*; #(
   parameter int FRAME_BITS = 64,
   parameter int AW         = 10
) (
   input  logic                  clock,
   input  mem_ctl_type           ctl,
   input  logic [AW-1:0]         wr_addr,
   input  logic [FRAME_BITS-1:0] wr_data,
   input  logic [AW-1:0]         rd_addr,
   output logic [FRAME_BITS-1:0] rd_data
);

   logic [FRAME_BITS-1:0] slots [1<<AW];
   logic [FRAME_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         slots[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= slots[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ verif/tb_frame_ring_with_peer_close_unit.sv @@
`timescale 1ns / 1ps

module tb_frame_ring_with_peer_close_unit;
   import frpc_pkg::*;

   localparam int RING_DEPTH  = 1024;
   localparam int MAX_LOG2    = $clog2(RING_DEPTH);
   localparam int SETTLE      = 4;
   localparam int LONG_HOLD   = 300;
   localparam int CYCLE_LIMIT = 1_000_000;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [FRAME_W-1:0]  frame;
      logic                notify;
      logic [ID_W-1:0]     notify_id;
      logic [COUNT_W-1:0]  fill;
      logic [COUNT_W-1:0]  free;
   } ring_result_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [95:0]  req_tdata = '0;    // frame_in[63:0], waiter_id[94:64], pad
   logic [3:0]   req_tuser = '0;    // action[3:0]
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [119:0] rsp_tdata;         // frame_out[63:0], notify_id[94:64],
                                    // fill_count[105:95], free_count[116:106], pad
   logic [3:0]   rsp_tuser;         // status[2:0], notify_valid[3]
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [2:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   frame_ring_with_peer_close_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predicted queue state
   logic [FRAME_W-1:0] slot_mem [0:RING_DEPTH-1];
   logic [COUNT_W-1:0] wr_ptr = '0;
   logic [COUNT_W-1:0] rd_ptr = '0;
   presence_type       wr_pres = PRES_NONE;
   presence_type       rd_pres = PRES_NONE;
   logic [BELL_W-1:0]  wr_bell = '0;
   logic [BELL_W-1:0]  rd_bell = '0;
   logic [3:0]         cap_log2_q = CAP_LOG2_RESET;
   logic               stream_q = 1'b0;

   ring_result_type pending_results[$];
   int           errors = 0;
   int           cycles = 0;
   bit           no_gaps = 1'b0;
   int           hold_request = 0;

   function automatic int slots_in_use();
      int k;
      k = cap_log2_q;
      if (k < 1) k = 1;
      if (k > MAX_LOG2) k = MAX_LOG2;
      return 1 << k;
   endfunction

   function automatic logic wake_peer(inout logic [BELL_W-1:0] bell,
                                      output logic [ID_W-1:0] id);
      id = '0;
      if (bell == '0 || (bell & BELL_RUNG) != '0) return 1'b0;
      id = bell[ID_W-1:0];
      bell = bell | BELL_RUNG;
      return 1'b1;
   endfunction

   function automatic ring_result_type advance_ring(logic [3:0] op,
                                                    logic [FRAME_W-1:0] frame,
                                                    logic [ID_W-1:0] wid);
      ring_result_type r;
      int cap;
      int fill;
      r = '0;
      r.status = ST_OK;
      cap = slots_in_use();
      fill = int'(COUNT_W'(wr_ptr - rd_ptr));
      case (op)
         ACT_PUSH: begin
            if (fill < cap) begin
               slot_mem[int'(wr_ptr) & (cap - 1)] = frame;
               wr_ptr = wr_ptr + 1'b1;
               r.notify = wake_peer(rd_bell, r.notify_id);
            end else if (!stream_q && rd_pres == PRES_GONE) begin
               rd_pres = PRES_FROZEN;
               r.status = ST_READER_TERM;
            end else begin
               r.status = ST_WOULD_BLOCK;
            end
         end
         ACT_POP: begin
            if (fill != 0) begin
               r.frame = slot_mem[int'(rd_ptr) & (cap - 1)];
               rd_ptr = rd_ptr + 1'b1;
               r.notify = wake_peer(wr_bell, r.notify_id);
            end else if (!stream_q && wr_pres == PRES_GONE) begin
               wr_pres = PRES_FROZEN;
               r.status = ST_WRITER_CLOS;
            end else begin
               r.status = ST_WOULD_BLOCK;
            end
         end
         ACT_W_ATTACH: wr_pres = PRES_ATTACHED;
         ACT_W_DETACH: begin
            if (wr_pres != PRES_NONE) wr_pres = PRES_GONE;
            wr_bell = '0;
         end
         ACT_R_ATTACH: rd_pres = PRES_ATTACHED;
         ACT_R_DETACH: begin
            if (rd_pres != PRES_NONE) rd_pres = PRES_GONE;
            rd_bell = '0;
         end
         ACT_HANG_WBELL: begin
            if (wid == '0) r.status = ST_INVALID_ARG;
            else wr_bell = {1'b0, wid};
         end
         ACT_HANG_RBELL: begin
            if (wid == '0) r.status = ST_INVALID_ARG;
            else rd_bell = {1'b0, wid};
         end
         ACT_TAKE_WBELL: wr_bell = '0;
         ACT_TAKE_RBELL: rd_bell = '0;
         default: r.status = ST_INVALID_ARG;
      endcase
      fill = int'(COUNT_W'(wr_ptr - rd_ptr));
      r.fill = COUNT_W'(fill);
      r.free = (fill >= cap) ? '0 : COUNT_W'(cap - fill);
      return r;
   endfunction

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endfunction

   // result side: random stalls, long hold-off on request, compare
   initial begin
      int stall;
      int hold_left;
      ring_result_type want;
      stall = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               $error("result transaction with nothing expected");
               errors++;
            end else begin
               want = pending_results.pop_front();
               check_field("status", want.status, rsp_tuser[2:0]);
               check_field("frame_out", want.frame, rsp_tdata[63:0]);
               check_field("notify_valid", want.notify, rsp_tuser[3]);
               check_field("notify_id", want.notify_id, rsp_tdata[94:64]);
               check_field("fill_count", want.fill, rsp_tdata[105:95]);
               check_field("free_count", want.free, rsp_tdata[116:106]);
            end
            stall = no_gaps ? 0 : $urandom_range(0, 11);
         end
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall > 0) begin
            stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic send_item(input logic [3:0] op, input logic [FRAME_W-1:0] frame,
                            input logic [ID_W-1:0] wid);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {1'b0, wid, frame};
      req_tuser <= op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_results.push_back(advance_ring(op, frame, wid));
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(input logic reg_idx, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {reg_idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (reg_idx == REG_CAP_LOG2) begin
         cap_log2_q = value[3:0];
         wr_ptr = '0;
         rd_ptr = '0;
      end else begin
         stream_q = value[0];
      end
   endtask

   task automatic configure(input logic [3:0] cap_setting, input logic stream);
      wait_idle();
      csr_write(REG_CAP_LOG2, {28'($urandom()), cap_setting});
      csr_write(REG_STREAM, {31'($urandom()), stream});
   endtask

   function automatic logic [FRAME_W-1:0] any_frame();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [ID_W-1:0] any_id();
      if ($urandom_range(0, 7) == 0) return '0;
      return ID_W'($urandom());
   endfunction

   task automatic test_directed();
      send_item(ACT_POP, '0, '0);
      send_item(ACT_HANG_RBELL, '0, '0);
      send_item(ACT_HANG_RBELL, '0, '1);
      send_item(ACT_HANG_WBELL, '0, 31'd1);
      send_item(ACT_PUSH, '1, '0);
      send_item(ACT_PUSH, '0, '1);
      send_item(ACT_POP, '0, '0);
      send_item(ACT_POP, '0, '0);
      send_item(ACT_POP, '0, '0);
      send_item(ACT_W_ATTACH, '0, '0);
      send_item(ACT_W_DETACH, '0, '0);
      send_item(ACT_POP, '0, '0);
      send_item(ACT_POP, '0, '0);
      send_item(ACT_R_ATTACH, '0, '0);
      send_item(ACT_R_DETACH, '0, '0);
      send_item(ACT_TAKE_WBELL, '0, '0);
      send_item(ACT_TAKE_RBELL, '0, '0);
      for (int c = int'(ACT_TAKE_RBELL) + 1; c < 2**ACTION_W; c++)
         send_item(ACTION_W'(c), any_frame(), any_id());
   endtask

   task automatic test_peer_close();
      configure(4'd1, 1'b0);
      send_item(ACT_R_ATTACH, '0, '0);
      send_item(ACT_R_DETACH, '0, '0);
      send_item(ACT_PUSH, any_frame(), '0);
      send_item(ACT_PUSH, any_frame(), '0);
      send_item(ACT_PUSH, any_frame(), '0);
      send_item(ACT_PUSH, any_frame(), '0);
      send_item(ACT_R_DETACH, '0, '0);
      send_item(ACT_PUSH, any_frame(), '0);
      configure(4'd1, 1'b1);
      send_item(ACT_W_ATTACH, '0, '0);
      send_item(ACT_W_DETACH, '0, '0);
      send_item(ACT_R_DETACH, '0, '0);
      send_item(ACT_PUSH, any_frame(), '0);
      send_item(ACT_PUSH, any_frame(), '0);
      send_item(ACT_POP, '0, '0);
      send_item(ACT_POP, '0, '0);
      configure(4'd1, 1'b0);
      send_item(ACT_POP, '0, '0);
      send_item(ACT_PUSH, any_frame(), '0);
      send_item(ACT_POP, '0, '0);
      send_item(ACT_POP, '0, '0);
   endtask

   task automatic test_capacity(input logic [3:0] cap_setting);
      int cap;
      int n;
      configure(cap_setting, 1'b0);
      cap = slots_in_use();
      n = (cap > 31) ? 32 : cap + 1;
      no_gaps = (cap > 8);
      repeat (n) send_item(ACT_PUSH, any_frame(), '0);
      repeat (n) send_item(ACT_POP, '0, '0);
      no_gaps = 1'b0;
   endtask

   task automatic test_backpressure();
      configure(4'd6, 1'b0);
      no_gaps = 1'b1;
      hold_request = LONG_HOLD;
      repeat (40) send_item(ACT_PUSH, any_frame(), '0);
      repeat (40) send_item(ACT_POP, '0, '0);
      no_gaps = 1'b0;
   endtask

   task automatic test_random_phase(input logic [3:0] cap_setting, input logic stream,
                                    input int push_pct, input int count);
      int r;
      logic [3:0] op;
      configure(cap_setting, stream);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 24) == 0) no_gaps = !no_gaps;
         r = $urandom_range(0, 99);
         if (r < 72) op = ($urandom_range(0, 99) < push_pct) ? ACT_PUSH : ACT_POP;
         else if (r < 75) op = ACT_W_ATTACH;
         else if (r < 78) op = ACT_W_DETACH;
         else if (r < 81) op = ACT_R_ATTACH;
         else if (r < 84) op = ACT_R_DETACH;
         else if (r < 89) op = ACT_HANG_WBELL;
         else if (r < 94) op = ACT_HANG_RBELL;
         else if (r < 96) op = ACT_TAKE_WBELL;
         else if (r < 98) op = ACT_TAKE_RBELL;
         else op = ACTION_W'($urandom_range(int'(ACT_TAKE_RBELL) + 1, 2**ACTION_W - 1));
         send_item(op, any_frame(), any_id());
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_peer_close();
      test_capacity(4'd1);
      test_capacity(4'd0);
      test_capacity(4'd2);
      test_capacity(4'd15);
      test_backpressure();
      test_random_phase(4'd2, 1'b0, 50, 80);
      test_random_phase(4'd3, 1'b1, 55, 80);
      test_random_phase(4'd1, 1'b0, 50, 80);
      test_random_phase(4'd4, 1'b0, 65, 90);
      test_random_phase(4'd10, 1'b0, 80, 80);
      test_random_phase(4'd5, 1'b1, 40, 80);
      wait_idle();
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
